// ----- rtl/dsc_pkg.sv -----
package dsc_pkg;

  // Field widths fixed by the page and segment formats.
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned BYTES_W = 32;
  localparam int unsigned LEN_W   = 64;
  localparam int unsigned NUM_W   = 16;

  // Configuration port geometry.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register index, taken from paddr[2].
  localparam logic REG_SEG_LIMIT = 1'b0;

  localparam logic [NUM_W-1:0] SEG_LIMIT_RESET = 16'hFFFF;

  // Result status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [ADDR_W-1:0] seg_base;
    logic [LEN_W-1:0]  seg_length;
    logic [NUM_W-1:0]  seg_number;
    logic              status;
    logic              run_end;
  } dsc_result_t;

  // Work handed from the front to the back: one or two results per command.
  typedef struct packed {
    dsc_result_t first;
    logic        has_second;
    dsc_result_t second;
  } dsc_cmd_t;

endpackage

// ----- rtl/dsc_page_if.sv -----
interface dsc_page_if;
  logic        valid;
  logic        ready;
  logic [63:0] page_addr;
  logic [31:0] page_bytes;
  logic        last_page;

  modport source (output valid, page_addr, page_bytes, last_page, input ready);
  modport sink (input valid, page_addr, page_bytes, last_page, output ready);
endinterface

// ----- rtl/dsc_seg_if.sv -----
interface dsc_seg_if;
  logic        valid;
  logic        ready;
  logic [63:0] seg_base;
  logic [63:0] seg_length;
  logic [15:0] seg_number;
  logic        status;
  logic        run_end;

  modport source (output valid, seg_base, seg_length, seg_number, status, run_end,
                  input ready);
  modport sink (input valid, seg_base, seg_length, seg_number, status, run_end,
                output ready);
endinterface

// ----- rtl/dsc_front.sv -----
module dsc_front (
  input  logic                             clk,
  input  logic                             rst,
  dsc_page_if.sink                         pages,
  input  logic [dsc_pkg::NUM_W-1:0]        seg_limit,
  input  logic                             cmd_ready,
  output logic                             cmd_push,
  output dsc_pkg::dsc_cmd_t                cmd
);
  import dsc_pkg::*;

  logic [ADDR_W-1:0] open_base, open_base_next;
  logic [LEN_W-1:0]  open_length, open_length_next;
  logic [NUM_W-1:0]  emitted_count, emitted_count_next;
  logic              run_open, run_open_next;
  logic              run_failed, run_failed_next;

  logic [ADDR_W-1:0] expect_addr;
  logic [LEN_W-1:0]  page_len;
  logic [LEN_W-1:0]  grown_len;
  logic [NUM_W-1:0]  count_inc;
  logic              contiguous;
  logic              accept;

  // Closing result of a segment: the segment itself, or the overflow error.
  function automatic dsc_result_t flush_seg(input logic [ADDR_W-1:0] base,
                                            input logic [LEN_W-1:0]  len,
                                            input logic [NUM_W-1:0]  num,
                                            input logic [NUM_W-1:0]  limit,
                                            input logic              last);
    dsc_result_t r;
    if (num >= limit) begin
      r.seg_base   = '0;
      r.seg_length = '0;
      r.seg_number = num;
      r.status     = STATUS_OVERFLOW;
      r.run_end    = 1'b1;
    end else begin
      r.seg_base   = base;
      r.seg_length = len;
      r.seg_number = num;
      r.status     = STATUS_OK;
      r.run_end    = last;
    end
    return r;
  endfunction

  assign pages.ready = cmd_ready;
  assign accept      = pages.valid && cmd_ready;

  // Contiguity test and merged length.
  assign expect_addr = open_base + open_length;
  assign contiguous  = (pages.page_addr == expect_addr);
  assign page_len    = {{(LEN_W-BYTES_W){1'b0}}, pages.page_bytes};
  assign grown_len   = open_length + page_len;
  assign count_inc   = emitted_count + NUM_W'(1);

  // Classify the page and update the open segment.
  always_comb begin
    open_base_next     = open_base;
    open_length_next   = open_length;
    emitted_count_next = emitted_count;
    run_open_next      = run_open;
    run_failed_next    = run_failed;
    cmd_push           = 1'b0;
    cmd                = '0;

    if (accept) begin
      if (run_failed) begin
        // Swallow the rest of a failed run.
        if (pages.last_page) begin
          run_failed_next = 1'b0;
        end
      end else if (!run_open) begin
        if (pages.last_page) begin
          cmd_push  = 1'b1;
          cmd.first = flush_seg(pages.page_addr, page_len, '0, seg_limit, 1'b1);
        end else begin
          open_base_next     = pages.page_addr;
          open_length_next   = page_len;
          emitted_count_next = '0;
          run_open_next      = 1'b1;
        end
      end else if (contiguous) begin
        if (pages.last_page) begin
          cmd_push  = 1'b1;
          cmd.first = flush_seg(open_base, grown_len, emitted_count, seg_limit, 1'b1);
          run_open_next      = 1'b0;
          emitted_count_next = '0;
          open_base_next     = '0;
          open_length_next   = '0;
        end else begin
          open_length_next = grown_len;
        end
      end else begin
        // Break: emit the open segment, then fail, open or flush a new one.
        cmd_push  = 1'b1;
        cmd.first = flush_seg(open_base, open_length, emitted_count, seg_limit,
                              1'b0);
        if (emitted_count >= seg_limit) begin
          run_open_next      = 1'b0;
          emitted_count_next = '0;
          open_base_next     = '0;
          open_length_next   = '0;
          run_failed_next    = !pages.last_page;
        end else if (pages.last_page) begin
          cmd.has_second     = 1'b1;
          cmd.second         = flush_seg(pages.page_addr, page_len, count_inc,
                                         seg_limit, 1'b1);
          run_open_next      = 1'b0;
          emitted_count_next = '0;
          open_base_next     = '0;
          open_length_next   = '0;
        end else begin
          open_base_next     = pages.page_addr;
          open_length_next   = page_len;
          emitted_count_next = count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_base     <= '0;
      open_length   <= '0;
      emitted_count <= '0;
      run_open      <= 1'b0;
      run_failed    <= 1'b0;
    end else begin
      open_base     <= open_base_next;
      open_length   <= open_length_next;
      emitted_count <= emitted_count_next;
      run_open      <= run_open_next;
      run_failed    <= run_failed_next;
    end
  end

endmodule

// ----- rtl/dsc_queue.sv -----
module dsc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dsc_pkg::dsc_cmd_t push_cmd,
  output logic              push_ready,
  input  logic              pop,
  output logic              head_valid,
  output dsc_pkg::dsc_cmd_t head_cmd
);
  import dsc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  dsc_cmd_t          slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign push_ready = (count != FULL_CNT);
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  // Storage for queued commands.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/dsc_back.sv -----
module dsc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  dsc_pkg::dsc_cmd_t head_cmd,
  output logic              pop,
  dsc_seg_if.source         segs
);
  import dsc_pkg::*;

  logic        out_valid;
  dsc_result_t out_res;
  logic        second_phase;
  logic        load;
  dsc_result_t pick;

  // The output register refills when empty or when its item is taken.
  assign load = !out_valid || segs.ready;
  assign pick = second_phase ? head_cmd.second : head_cmd.first;
  assign pop  = load && head_valid && (second_phase || !head_cmd.has_second);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      second_phase <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        second_phase <= !second_phase && head_cmd.has_second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_res <= pick;
    end
  end

  assign segs.valid      = out_valid;
  assign segs.seg_base   = out_res.seg_base;
  assign segs.seg_length = out_res.seg_length;
  assign segs.seg_number = out_res.seg_number;
  assign segs.status     = out_res.status;
  assign segs.run_end    = out_res.run_end;

endmodule

// ----- rtl/dsc_cfg.sv -----
module dsc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dsc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [dsc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [dsc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [dsc_pkg::NUM_W-1:0]        seg_limit
);
  import dsc_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_SEG_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_limit <= SEG_LIMIT_RESET;
    end else if (wr_en) begin
      seg_limit <= pwdata[NUM_W-1:0];
    end
  end

  // Read back; unused bits and unmapped addresses read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SEG_LIMIT) begin
      prdata = {{(APB_DATA_W-NUM_W){1'b0}}, seg_limit};
    end
  end

endmodule

// ----- rtl/dma_segment_coalescer_core.sv -----
// Scatter-gather coalescer: pages arrive one per item (bus address, size,
// last flag) and leave as contiguous segments with their index in the run.
// A page is accepted every cycle while the result queue has room; the
// contiguity check is a single 64-bit add and compare in the front stage.
// Results leave one per cycle while the output is not stalled, through the
// queue and then a registered output, so a run whose last page both closes a
// segment and flushes a new one yields two results in turn. The queue of
// QUEUE_DEPTH commands absorbs those bursts and output stalls. When a run
// exceeds the segment limit, one error result closes it and its remaining
// pages produce nothing.
module dma_segment_coalescer_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  dsc_page_if.sink                         pages,
  dsc_seg_if.source                        segs,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dsc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [dsc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [dsc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import dsc_pkg::*;

  logic [NUM_W-1:0] seg_limit;
  logic             cmd_push, cmd_ready;
  dsc_cmd_t         cmd;
  logic             head_valid, head_pop;
  dsc_cmd_t         head_cmd;

  dsc_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .seg_limit    (seg_limit)
  );

  dsc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .pages        (pages),
    .seg_limit    (seg_limit),
    .cmd_ready    (cmd_ready),
    .cmd_push     (cmd_push),
    .cmd          (cmd)
  );

  dsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .push_ready (cmd_ready),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  dsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (head_pop),
    .segs       (segs)
  );

endmodule

// ----- tb/dma_segment_coalescer_core_test.sv -----
`timescale 1ns / 1ps

module dma_segment_coalescer_core_test;
  import dsc_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned QUIET_LIMIT   = 3000;
  localparam int unsigned PHASE_PAGES   = 150;
  localparam int unsigned NUM_PHASES    = 8;

  localparam logic [APB_ADDR_W-1:0] MAX_SEG_ADDR = {REG_SEG_LIMIT, 2'b00};

  // Tracks the open segment of the current run and the segments it must produce.
  class segment_tracker;
    logic [NUM_W-1:0]  max_segs = SEG_LIMIT_RESET;
    logic [ADDR_W-1:0] open_base = '0;
    logic [LEN_W-1:0]  open_len = '0;
    logic [NUM_W-1:0]  seg_count = '0;
    bit                seg_open = 1'b0;
    bit                run_dead = 1'b0;
    dsc_result_t       due_segments[$];
    int unsigned       fail_count = 0;

    function void set_limit(logic [NUM_W-1:0] value);
      max_segs = value;
    endfunction

    function int unsigned segments_due();
      return due_segments.size();
    endfunction

    function void close_run();
      seg_open  = 1'b0;
      seg_count = '0;
      open_base = '0;
      open_len  = '0;
    endfunction

    // Queue the open segment, or the overflow error once the limit is reached.
    function bit emit_open(bit at_end);
      dsc_result_t seg;
      seg.seg_number = seg_count;
      if (seg_count >= max_segs) begin
        seg.seg_base   = '0;
        seg.seg_length = '0;
        seg.status     = STATUS_OVERFLOW;
        seg.run_end    = 1'b1;
        due_segments.push_back(seg);
        return 1'b0;
      end
      seg.seg_base   = open_base;
      seg.seg_length = open_len;
      seg.status     = STATUS_OK;
      seg.run_end    = at_end;
      due_segments.push_back(seg);
      seg_count = seg_count + 1'b1;
      return 1'b1;
    endfunction

    function void note_page(logic [ADDR_W-1:0] addr, logic [BYTES_W-1:0] nbytes, bit last);
      // A failed run swallows everything up to and including its last page.
      if (run_dead) begin
        if (last) run_dead = 1'b0;
        return;
      end
      if (!seg_open) begin
        open_base = addr;
        open_len  = LEN_W'(nbytes);
        seg_count = '0;
        seg_open  = 1'b1;
      end else if (addr == open_base + open_len) begin
        open_len = open_len + LEN_W'(nbytes);
      end else begin
        if (!emit_open(1'b0)) begin
          close_run();
          run_dead = !last;
          return;
        end
        open_base = addr;
        open_len  = LEN_W'(nbytes);
      end
      // The last page flushes whatever segment is still open.
      if (last) begin
        void'(emit_open(1'b1));
        close_run();
      end
    endfunction

    function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        fail_count++;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_segment(dsc_result_t got);
      dsc_result_t want;
      if (due_segments.size() == 0) begin
        $display("%0t: segment with none expected: expected nothing, got base %h length %h",
                 $time, got.seg_base, got.seg_length);
        fail_count++;
        return;
      end
      want = due_segments.pop_front();
      void'(field_ok("seg_base", want.seg_base, got.seg_base));
      void'(field_ok("seg_length", want.seg_length, got.seg_length));
      void'(field_ok("seg_number", 64'(want.seg_number), 64'(got.seg_number)));
      void'(field_ok("status", 64'(want.status), 64'(got.status)));
      void'(field_ok("run_end", 64'(want.run_end), 64'(got.run_end)));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  dsc_page_if page_bus ();
  dsc_seg_if  seg_bus ();

  segment_tracker sb;

  // Stimulus state shared by the page generator and the sink.
  logic [ADDR_W-1:0] next_addr;
  int unsigned       run_left;
  bit                idle_on;
  bit                hold_request;

  dma_segment_coalescer_core dut (
    .clk     (clk),
    .rst     (rst),
    .pages   (page_bus),
    .segs    (seg_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Offer one page, after an optional gap, and hold it until it is accepted.
  task automatic send_page(logic [ADDR_W-1:0] addr, logic [BYTES_W-1:0] nbytes, logic last);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      @(negedge clk);
      page_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    page_bus.valid      <= 1'b1;
    page_bus.page_addr  <= addr;
    page_bus.page_bytes <= nbytes;
    page_bus.last_page  <= last;
    do @(posedge clk); while (!page_bus.ready);
    sb.note_page(addr, nbytes, last);
  endtask

  task automatic stop_pages();
    @(negedge clk);
    page_bus.valid <= 1'b0;
  endtask

  // Wait until every queued segment has come out and the block has gone quiet.
  task automatic settle();
    while (sb.segments_due() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the segment limit, then read it back.
  task automatic write_seg_limit(logic [NUM_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_SEG_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_limit(value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    void'(sb.field_ok("seg_limit readback", 64'(value), 64'(prdata)));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Runs of mostly contiguous pages, with breaks, overlaps and stray addresses mixed in.
  task automatic send_random_pages(int unsigned count, int unsigned longest_run);
    logic [ADDR_W-1:0]  addr;
    logic [BYTES_W-1:0] nbytes;
    logic               last;
    for (int unsigned i = 0; i < count; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, longest_run);
        if ($urandom_range(0, 3) == 0) next_addr = {$urandom, $urandom};
      end
      case ($urandom_range(0, 9))
        0: addr = {$urandom, $urandom};
        1: addr = next_addr + 64'($urandom_range(1, 8)) * 64'd4096;
        2: addr = next_addr - 64'd4096;
        default: addr = next_addr;
      endcase
      case ($urandom_range(0, 9))
        0: nbytes = '0;
        1: nbytes = $urandom;
        2: nbytes = '1;
        3: nbytes = BYTES_W'($urandom_range(1, 4095));
        default: nbytes = BYTES_W'(4096 * $urandom_range(1, 4));
      endcase
      last = (run_left == 1) || ($urandom_range(0, 19) == 0);
      run_left = last ? 0 : run_left - 1;
      next_addr = addr + ADDR_W'(nbytes);
      send_page(addr, nbytes, last);
    end
  endtask

  // Segment sink: random stalls, one long hold on request, then check each item.
  initial begin : seg_sink
    int unsigned stall;
    dsc_result_t got;
    seg_bus.ready = 1'b1;
    forever begin
      stall = idle_on ? $urandom_range(0, 8) : 0;
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        @(negedge clk);
        seg_bus.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk);
        seg_bus.ready <= 1'b1;
      end
      do @(posedge clk); while (!(seg_bus.valid && !rst));
      got = {seg_bus.seg_base, seg_bus.seg_length, seg_bus.seg_number,
             seg_bus.status, seg_bus.run_end};
      sb.check_segment(got);
    end
  end

  // Ends the run when neither side has moved an item for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((page_bus.valid && page_bus.ready) || (seg_bus.valid && seg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int unsigned limit;
    clk                 = 1'b0;
    rst                 = 1'b1;
    page_bus.valid      = 1'b0;
    page_bus.page_addr  = '0;
    page_bus.page_bytes = '0;
    page_bus.last_page  = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    sb                  = new;
    next_addr           = {$urandom, $urandom};
    run_left            = 0;
    idle_on             = 1'b1;
    hold_request        = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset limit: zero page, wrapping contiguity, zero-byte merge, break on the last page.
    send_page(64'h0, 32'h0, 1'b1);
    send_page(64'hFFFF_FFFF_FFFF_F000, 32'h0000_1000, 1'b0);
    send_page(64'h0, 32'hFFFF_FFFF, 1'b0);
    send_page(64'h0000_0000_FFFF_FFFF, 32'h0, 1'b0);
    send_page(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_page(64'h1000, 32'h1000, 1'b0);
    send_page(64'h3000, 32'h1000, 1'b0);
    send_page(64'h4000, 32'h2000, 1'b1);
    send_page(64'hABCD_EF01_2345_6789, 32'h0, 1'b1);
    stop_pages();
    settle();

    // Limit of one: overflow mid-run swallows the rest, overflow on the final flush.
    write_seg_limit(16'd1);
    send_page(64'hA000, 32'h100, 1'b0);
    send_page(64'hB000, 32'h100, 1'b0);
    send_page(64'hC000, 32'h100, 1'b0);
    send_page(64'hD000, 32'h100, 1'b1);
    send_page(64'h5555_5555_5555_5555, 32'hFFFF_FFFF, 1'b1);
    send_page(64'h100, 32'h800, 1'b0);
    send_page(64'h2000, 32'h10, 1'b1);
    stop_pages();
    settle();

    // Limit of zero: every run fails on its first segment.
    write_seg_limit(16'd0);
    send_page(64'h7000, 32'h10, 1'b1);
    send_page(64'h8000, 32'h10, 1'b0);
    send_page(64'h8010, 32'h10, 1'b0);
    send_page(64'h9000, 32'h10, 1'b0);
    send_page(64'h9999, 32'h1, 1'b1);
    stop_pages();
    settle();

    // Random phases; runs may straddle a limit change.
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: limit = 2;
        1: limit = 1;
        2: limit = 0;
        3: limit = 3;
        4: limit = 65535;
        5: limit = 4;
        6: limit = $urandom_range(1, 6);
        default: limit = 5;
      endcase
      write_seg_limit(NUM_W'(limit));
      idle_on = (p != 3) && (p != 5);
      if (p == 5) hold_request = 1'b1;
      send_random_pages(PHASE_PAGES, (p == 4) ? 24 : 8);
      stop_pages();
      settle();
    end

    if (sb.fail_count == 0 && sb.segments_due() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
